@@ rtl/sp2c_pkg.sv @@
package sp2c_pkg;

    // Payload and datapath widths
    localparam int DW     = 32;  // magnitude, phase and result words
    localparam int XW     = 48;  // CORDIC x/y, Q16.30 with headroom for the gain
    localparam int ZW     = 34;  // phase and CORDIC angle
    localparam int NW     = 13;  // frame_length register
    localparam int BW     = 12;  // bin counter
    localparam int RW     = XW - 14; // rounded Q16.16 before saturation
    localparam int PW     = DW + 31; // magnitude times gain
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam int MAX_FRAME     = 4096;
    localparam int CORDIC_STAGES = 24;

    // Register map: word index taken from paddr[2]
    localparam logic REG_FRAME_LEN = 1'b0;

    localparam logic [NW-1:0] FRAME_LEN_RESET = NW'(64);
    localparam logic [NW-1:0] FRAME_MIN       = NW'(4);
    localparam logic [NW-1:0] FRAME_CAP       = NW'((MAX_FRAME < 4096) ? MAX_FRAME : 4096);

    localparam logic signed [ZW-1:0] PI_Q28      = ZW'(64'sd843314857);
    localparam logic signed [ZW-1:0] TWO_PI_Q28  = ZW'(64'sd1686629713);
    localparam logic signed [ZW-1:0] HALF_PI_Q28 = ZW'(64'sd421657428);
    localparam logic [29:0]          GAIN_Q30    = 30'd652032874;

    localparam int ATAN_LOW [0:9] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149
    };

    // Arctangent of 2^-i in Q2.30, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic signed [ZW-1:0] a;
        if (i < 10) begin
            a = ZW'(ATAN_LOW[i]);
        end else if (i <= 30) begin
            a = ZW'(64'sd1 <<< (30 - i));
        end else begin
            a = '0;
        end
        return a;
    endfunction

    typedef struct packed {
        logic flip;       // phase folded by pi: negate x and y
        logic zero_all;   // bin above half: both parts zero
        logic zero_imag;  // DC or Nyquist bin
        logic last;       // last bin of the frame
    } t_side;

endpackage

@@ rtl/sp2c_if.sv @@
interface sp2c_bin_if;
    logic                  valid;
    logic                  ready;
    logic signed [31:0]    magnitude;
    logic signed [31:0]    phase;

    modport source (output valid, magnitude, phase, input ready);
    modport sink   (input valid, magnitude, phase, output ready);
endinterface

interface sp2c_res_if;
    logic                  valid;
    logic                  ready;
    logic signed [31:0]    real_part;
    logic signed [31:0]    imag_part;
    logic                  frame_end;

    modport source (output valid, real_part, imag_part, frame_end, input ready);
    modport sink   (input valid, real_part, imag_part, frame_end, output ready);
endinterface

@@ rtl/spectral_polar_to_cartesian.sv @@
// Channel  | Direction | Payload                                | Transfer when
// ---------+-----------+----------------------------------------+------------------
// i_bin    | in        | magnitude Q16.16, phase Q4.28 rad      | valid && ready
// o_res    | out       | real_part, imag_part Q16.16, frame_end | valid && ready
// APB      | in/out    | frame_length at byte address 0         | psel&penable&pwrite
//
// One bin per cycle sustained while o_res is ready; the pipeline has two front
// stages for phase wrap/fold and the gain multiply, one cell per CORDIC
// iteration, and two back stages for rounding and saturation.
// Synchronous active-low reset clears all valid flags, the bin counter and
// sets frame_length to 64. Each stage holds its item when the next one is full
// and stalled, so bubbles collapse and i_bin keeps accepting while a result
// waits at o_res until all CORDIC_STAGES + 4 stages hold an item.
module spectral_polar_to_cartesian #(
    parameter int CORDIC_STAGES = sp2c_pkg::CORDIC_STAGES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    sp2c_bin_if.sink                          i_bin,
    sp2c_res_if.source                        o_res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sp2c_pkg::APB_AW-1:0]       paddr,
    input  logic [sp2c_pkg::APB_DW-1:0]       pwdata,
    output logic [sp2c_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);

    localparam int XW = sp2c_pkg::XW;
    localparam int ZW = sp2c_pkg::ZW;
    localparam int NW = sp2c_pkg::NW;

    logic [NW-1:0]           r_frame_len;

    // Cell chain: index k is the input of cell k, CORDIC_STAGES is the tail
    logic                    c_valid [0:CORDIC_STAGES];
    logic                    c_ready [0:CORDIC_STAGES];
    logic signed [XW-1:0]    c_x     [0:CORDIC_STAGES];
    logic signed [XW-1:0]    c_y     [0:CORDIC_STAGES];
    logic signed [ZW-1:0]    c_z     [0:CORDIC_STAGES];
    sp2c_pkg::t_side         c_side  [0:CORDIC_STAGES];

    // Configuration port: write in the access phase, no wait states
    assign pready = 1'b1;
    assign prdata = (paddr[2] == sp2c_pkg::REG_FRAME_LEN)
                    ? sp2c_pkg::APB_DW'(r_frame_len) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len <= sp2c_pkg::FRAME_LEN_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == sp2c_pkg::REG_FRAME_LEN)) begin
            r_frame_len <= pwdata[NW-1:0];
        end
    end

    // Front: bin counter, phase reduction, gain multiply
    sp2c_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_bin.valid),
        .o_ready        (i_bin.ready),
        .i_magnitude    (i_bin.magnitude),
        .i_phase        (i_bin.phase),
        .i_frame_length (r_frame_len),
        .o_valid        (c_valid[0]),
        .i_ready        (c_ready[0]),
        .o_x            (c_x[0]),
        .o_z            (c_z[0]),
        .o_side         (c_side[0])
    );

    // Start the rotation on the x axis
    assign c_y[0] = '0;

    // One rotation cell per CORDIC iteration
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
        sp2c_cell #(
            .IDX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k]),
            .o_ready (c_ready[k]),
            .i_x     (c_x[k]),
            .i_y     (c_y[k]),
            .i_z     (c_z[k]),
            .i_side  (c_side[k]),
            .o_valid (c_valid[k+1]),
            .i_ready (c_ready[k+1]),
            .o_x     (c_x[k+1]),
            .o_y     (c_y[k+1]),
            .o_z     (c_z[k+1]),
            .o_side  (c_side[k+1])
        );
    end

    // Back: undo the fold, round to Q16.16, mask quiet bins, saturate.
    // The residual angle of the last cell is not needed.
    sp2c_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c_valid[CORDIC_STAGES]),
        .o_ready (c_ready[CORDIC_STAGES]),
        .i_x     (c_x[CORDIC_STAGES]),
        .i_y     (c_y[CORDIC_STAGES]),
        .i_side  (c_side[CORDIC_STAGES]),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_real  (o_res.real_part),
        .o_imag  (o_res.imag_part),
        .o_end   (o_res.frame_end)
    );

endmodule

@@ rtl/sp2c_front.sv @@
module sp2c_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [sp2c_pkg::DW-1:0]       i_magnitude,
    input  logic signed [sp2c_pkg::DW-1:0]       i_phase,
    input  logic        [sp2c_pkg::NW-1:0]       i_frame_length,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [sp2c_pkg::XW-1:0]       o_x,
    output logic signed [sp2c_pkg::ZW-1:0]       o_z,
    output sp2c_pkg::t_side                      o_side
);

    localparam int NW = sp2c_pkg::NW;
    localparam int BW = sp2c_pkg::BW;
    localparam int ZW = sp2c_pkg::ZW;
    localparam int XW = sp2c_pkg::XW;
    localparam int PW = sp2c_pkg::PW;

    logic [BW-1:0]           r_bin;
    logic [BW-1:0]           n_bin;
    logic [NW-1:0]           len_clamped;
    logic [BW-1:0]           half;
    logic                    is_last;
    logic                    ready_a;
    logic                    ready_b;
    logic                    take;
    logic signed [ZW-1:0]    p_in;
    logic signed [ZW-1:0]    p_wrap;
    logic signed [ZW-1:0]    p_fold;
    logic                    fold;

    logic                    r_a_valid;
    logic signed [PW-1:0]    r_a_prod;
    logic signed [ZW-1:0]    r_a_p;
    sp2c_pkg::t_side         r_a_side;

    logic                    r_b_valid;
    logic signed [XW-1:0]    r_b_x;
    logic signed [ZW-1:0]    r_b_z;
    sp2c_pkg::t_side         r_b_side;

    assign ready_b = !r_b_valid || i_ready;
    assign ready_a = !r_a_valid || ready_b;
    assign o_ready = ready_a;
    assign take    = i_valid && ready_a;

    // Bin bookkeeping
    always_comb begin
        if (i_frame_length < sp2c_pkg::FRAME_MIN) begin
            len_clamped = sp2c_pkg::FRAME_MIN;
        end else if (i_frame_length > sp2c_pkg::FRAME_CAP) begin
            len_clamped = sp2c_pkg::FRAME_CAP;
        end else begin
            len_clamped = i_frame_length;
        end
        half    = len_clamped[NW-1:1];
        is_last = {1'b0, r_bin} >= (len_clamped - NW'(1));
        n_bin   = is_last ? '0 : r_bin + BW'(1);
    end

    // Wrap phase into [-pi, pi]
    always_comb begin
        p_in = ZW'(i_phase);
        if (p_in > sp2c_pkg::PI_Q28) begin
            p_wrap = p_in - sp2c_pkg::TWO_PI_Q28;
        end else if (p_in < -sp2c_pkg::PI_Q28) begin
            p_wrap = p_in + sp2c_pkg::TWO_PI_Q28;
        end else begin
            p_wrap = p_in;
        end
    end

    // Fold into [-pi/2, pi/2]
    always_comb begin
        fold = 1'b1;
        if (r_a_p > sp2c_pkg::HALF_PI_Q28) begin
            p_fold = r_a_p - sp2c_pkg::PI_Q28;
        end else if (r_a_p < -sp2c_pkg::HALF_PI_Q28) begin
            p_fold = r_a_p + sp2c_pkg::PI_Q28;
        end else begin
            p_fold = r_a_p;
            fold   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin     <= '0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (take) begin
                r_bin <= n_bin;
            end
            if (ready_a) begin
                r_a_valid <= i_valid;
            end
            if (ready_b) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_a_prod           <= PW'(i_magnitude) * PW'($signed({1'b0, sp2c_pkg::GAIN_Q30}));
            r_a_p              <= p_wrap;
            r_a_side.flip      <= 1'b0;
            r_a_side.zero_all  <= r_bin > half;
            r_a_side.zero_imag <= (r_bin == '0) || (r_bin == half);
            r_a_side.last      <= is_last;
        end
        if (ready_b && r_a_valid) begin
            r_b_x    <= XW'(r_a_prod >>> 16);
            r_b_z    <= p_fold <<< 2;
            r_b_side <= '{flip: fold, zero_all: r_a_side.zero_all,
                          zero_imag: r_a_side.zero_imag, last: r_a_side.last};
        end
    end

    assign o_valid = r_b_valid;
    assign o_x     = r_b_x;
    assign o_z     = r_b_z;
    assign o_side  = r_b_side;

endmodule

@@ rtl/sp2c_cell.sv @@
module sp2c_cell #(
    parameter int IDX = 0
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [sp2c_pkg::XW-1:0]       i_x,
    input  logic signed [sp2c_pkg::XW-1:0]       i_y,
    input  logic signed [sp2c_pkg::ZW-1:0]       i_z,
    input  sp2c_pkg::t_side                      i_side,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [sp2c_pkg::XW-1:0]       o_x,
    output logic signed [sp2c_pkg::XW-1:0]       o_y,
    output logic signed [sp2c_pkg::ZW-1:0]       o_z,
    output sp2c_pkg::t_side                      o_side
);

    localparam logic signed [sp2c_pkg::ZW-1:0] ANG = sp2c_pkg::atan_q30(IDX);

    logic                              r_valid;
    logic signed [sp2c_pkg::XW-1:0]    r_x;
    logic signed [sp2c_pkg::XW-1:0]    r_y;
    logic signed [sp2c_pkg::ZW-1:0]    r_z;
    sp2c_pkg::t_side                   r_side;
    logic signed [sp2c_pkg::XW-1:0]    dx;
    logic signed [sp2c_pkg::XW-1:0]    dy;

    assign o_ready = !r_valid || i_ready;
    assign dx      = i_y >>> IDX;
    assign dy      = i_x >>> IDX;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Rotate toward zero residual angle
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            if (!i_z[sp2c_pkg::ZW-1]) begin
                r_x <= i_x - dx;
                r_y <= i_y + dy;
                r_z <= i_z - ANG;
            end else begin
                r_x <= i_x + dx;
                r_y <= i_y - dy;
                r_z <= i_z + ANG;
            end
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

@@ rtl/sp2c_back.sv @@
module sp2c_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [sp2c_pkg::XW-1:0]       i_x,
    input  logic signed [sp2c_pkg::XW-1:0]       i_y,
    input  sp2c_pkg::t_side                      i_side,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [sp2c_pkg::DW-1:0]       o_real,
    output logic signed [sp2c_pkg::DW-1:0]       o_imag,
    output logic                                 o_end
);

    localparam int XW = sp2c_pkg::XW;
    localparam int RW = sp2c_pkg::RW;
    localparam int DW = sp2c_pkg::DW;

    localparam logic signed [RW:0] SAT_HI = (RW+1)'(64'sd2147483647);
    localparam logic signed [RW:0] SAT_LO = (RW+1)'(-64'sd2147483648);

    function automatic logic signed [DW-1:0] sat(input logic signed [RW:0] v);
        logic signed [DW-1:0] s;
        if (v > SAT_HI) begin
            s = {1'b0, {(DW-1){1'b1}}};
        end else if (v < SAT_LO) begin
            s = {1'b1, {(DW-1){1'b0}}};
        end else begin
            s = v[DW-1:0];
        end
        return s;
    endfunction

    logic                    ready_r;
    logic                    ready_o;
    logic signed [XW-1:0]    xs;
    logic signed [XW-1:0]    ys;
    logic signed [XW-1:0]    x_bias;
    logic signed [XW-1:0]    y_bias;
    logic signed [RW:0]      y_neg;

    logic                    r_r_valid;
    logic signed [RW-1:0]    r_r_x;
    logic signed [RW-1:0]    r_r_y;
    sp2c_pkg::t_side         r_r_side;

    logic                    r_o_valid;
    logic signed [DW-1:0]    r_o_real;
    logic signed [DW-1:0]    r_o_imag;
    logic                    r_o_end;

    assign ready_o = !r_o_valid || i_ready;
    assign ready_r = !r_r_valid || ready_o;
    assign o_ready = ready_r;

    assign xs     = i_side.flip ? -i_x : i_x;
    assign ys     = i_side.flip ? -i_y : i_y;
    assign x_bias = xs + XW'(8192);
    assign y_bias = ys + XW'(8192);
    assign y_neg  = -((RW+1)'(r_r_y));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (ready_r) begin
                r_r_valid <= i_valid;
            end
            if (ready_o) begin
                r_o_valid <= r_r_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_r && i_valid) begin
            r_r_x    <= x_bias[XW-1:14];
            r_r_y    <= y_bias[XW-1:14];
            r_r_side <= i_side;
        end
        if (ready_o && r_r_valid) begin
            if (r_r_side.zero_all) begin
                r_o_real <= '0;
                r_o_imag <= '0;
            end else begin
                r_o_real <= sat((RW+1)'(r_r_x));
                r_o_imag <= r_r_side.zero_imag ? '0 : sat(y_neg);
            end
            r_o_end <= r_r_side.last;
        end
    end

    assign o_valid = r_o_valid;
    assign o_real  = r_o_real;
    assign o_imag  = r_o_imag;
    assign o_end   = r_o_end;

endmodule

@@ rtl/sp2c_check.sv @@
module sp2c_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_real,
    input logic [31:0] i_out_imag,
    input logic        i_out_end
);

    // Reset drains the whole chain
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A sink that takes every result never stalls the source
    a_ready_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input stalled while output is ready");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_real)
            && $stable(i_out_imag) && $stable(i_out_end))
        else $error("stalled result changed");

    // No result without any input: an empty chain stays empty
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) && !i_in_valid |=> !i_out_valid)
        else $error("result appeared from an empty pipeline");

endmodule

bind spectral_polar_to_cartesian sp2c_check u_sp2c_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_bin.valid),
    .i_in_ready  (i_bin.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_real  (o_res.real_part),
    .i_out_imag  (o_res.imag_part),
    .i_out_end   (o_res.frame_end)
);
